>>> rtl/ttoi_pkg.sv
package ttoi_pkg;

   localparam int unsigned VALUE_WIDTH = 32;
   localparam int unsigned POS_WIDTH   = 16;

   // Saturation point of the character position counter.
   localparam logic [POS_WIDTH-1:0] MAX_LEN = 16'hFFFF;

   // Result status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_CONV  = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_BAD_BASE = 2'd3;

   // Configuration register indexes.
   localparam logic REG_RADIX  = 1'b0;
   localparam logic REG_SIGNED = 1'b1;

   localparam logic [7:0] NOT_A_DIGIT = 8'hFF;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic [POS_WIDTH-1:0]   end_index;
      logic [1:0]             status;
   } rsp_payload_type;

   // Digit value of a character in any base up to 36, or NOT_A_DIGIT.
   function automatic logic [7:0] digit_of(input logic [7:0] c);
      logic [7:0] d;
      begin
         if (c >= "0" && c <= "9") begin
            d = c - 8'h30;
         end else if (c >= "A" && c <= "Z") begin
            d = c - 8'h41 + 8'd10;
         end else if (c >= "a" && c <= "z") begin
            d = c - 8'h61 + 8'd10;
         end else begin
            d = NOT_A_DIGIT;
         end
         return d;
      end
   endfunction

   // Space, tab, line feed, vertical tab, form feed and carriage return.
   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

endpackage

>>> rtl/text_to_integer_parser.sv
// Streaming text-to-integer parser in the style of strtoul and strtol.
//
// Characters of a string enter on the req_ channel, one per transfer, with
// last set on the final character. The parser skips leading whitespace,
// takes an optional sign, detects an octal or hex prefix at radix 0 (hex
// also at 16), and accumulates digits. At the first character that is not
// a digit, or at the last character, one transfer on the rsp_ channel gives
// the value, the end index and a status. Characters after that result are
// consumed silently until last, and the next string then starts fresh.
//
// A character is accepted in every cycle unless the input stage stalls:
// one stage holds the incoming character, and its step (one 32 by 6 bit
// multiply-add against the per-string state) writes the result register
// that drives the rsp_ channel. When the receiver stalls, the result
// register holds its transfer, and the input stage stalls only once it
// holds a character that would make a new result; characters that make no
// result keep flowing. Reset is synchronous and clears both stages and the
// string state; the radix register returns to 10 and signed mode to off.
// Configuration is to be written through the APB port only while no string
// is in progress; the block itself does not enforce this.
module text_to_integer_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ttoi_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ttoi_pkg::rsp_payload_type rsp_payload,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [2:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);
   import ttoi_pkg::*;

   // Parser phases.
   localparam logic [2:0] PH_WS     = 3'd0;
   localparam logic [2:0] PH_SIGN   = 3'd1;
   localparam logic [2:0] PH_ZERO   = 3'd2;
   localparam logic [2:0] PH_ZX     = 3'd3;
   localparam logic [2:0] PH_DIGITS = 3'd4;
   localparam logic [2:0] PH_DRAIN  = 3'd5;

   localparam logic [VALUE_WIDTH-1:0] HALF_VAL = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic [VALUE_WIDTH-1:0] ALL_ONES = {VALUE_WIDTH{1'b1}};

   // Configuration registers.
   logic [5:0] radix_ff;
   logic       signed_mode_ff;

   // Input stage.
   logic            in_valid_ff;
   req_payload_type in_payload_ff;

   // Per-string state.
   logic [2:0]             phase_ff, phase_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic                   ovf_ff, ovf_in;
   logic                   neg_ff, neg_in;
   logic [5:0]             base_ff, base_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [POS_WIDTH-1:0]   fallback_ff, fallback_in;
   logic                   digits_ff, digits_in;

   // Result stage.
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // Step logic.
   logic                   proc_go;
   logic                   out_free;
   logic                   res_fire;
   logic [7:0]             c;
   logic                   lst;
   logic [7:0]             dig;
   logic [POS_WIDTH-1:0]   pos_adv;
   logic [5:0]             cur_base;
   logic [VALUE_WIDTH+5:0] prod;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_SIGNED) ? {31'b0, signed_mode_ff} : {26'b0, radix_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff       <= 6'd10;
         signed_mode_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready) begin
         unique case (paddr[2])
            REG_RADIX:  radix_ff       <= pwdata[5:0];
            REG_SIGNED: signed_mode_ff <= pwdata[0];
            default:    radix_ff       <= radix_ff;
         endcase
      end
   end

   assign c        = in_payload_ff.ch;
   assign lst      = in_payload_ff.last;
   assign dig      = digit_of(c);
   assign pos_adv  = (pos_ff < MAX_LEN) ? pos_ff + 16'd1 : pos_ff;
   assign cur_base = (phase_ff == PH_WS) ? radix_ff : base_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign proc_go   = in_valid_ff && (!res_fire || out_free);
   assign req_stall = in_valid_ff && !proc_go;

   // One character step. The state updates are formed first; a result, if
   // any, is then concluded from the updated state.
   always_comb begin
      logic                   take;
      logic [5:0]             take_base;
      logic                   conclude;
      logic                   bad_base;
      logic [POS_WIDTH-1:0]   conc_end;
      logic                   first;
      logic [VALUE_WIDTH-1:0] v;

      phase_in    = phase_ff;
      acc_in      = acc_ff;
      ovf_in      = ovf_ff;
      neg_in      = neg_ff;
      base_in     = base_ff;
      pos_in      = pos_ff;
      fallback_in = fallback_ff;
      digits_in   = digits_ff;
      take        = 1'b0;
      take_base   = cur_base;
      conclude    = 1'b0;
      bad_base    = 1'b0;
      conc_end    = pos_ff;
      first       = 1'b0;
      prod        = '0;

      unique case (phase_ff)
         PH_WS: begin
            base_in = radix_ff;
            if (radix_ff == 6'd1 || radix_ff > 6'd36) begin
               bad_base = 1'b1;
            end else if (is_space(c)) begin
               pos_in   = pos_adv;
               conclude = lst;
               conc_end = pos_adv;
            end else if (c == "-" || c == "+") begin
               neg_in   = (c == "-");
               pos_in   = pos_adv;
               phase_in = PH_SIGN;
               conclude = lst;
               conc_end = pos_adv;
            end else begin
               first = 1'b1;
            end
         end
         PH_SIGN: first = 1'b1;
         PH_ZERO: begin
            if (c == "x" || c == "X") begin
               phase_in = PH_ZX;
               pos_in   = pos_adv;
               conclude = lst;
               conc_end = fallback_ff;
            end else begin
               take = 1'b1;
            end
         end
         PH_ZX: begin
            if (dig < 8'd16) begin
               base_in   = 6'd16;
               take_base = 6'd16;
               take      = 1'b1;
            end else begin
               conclude = 1'b1;
               conc_end = fallback_ff;
            end
         end
         PH_DIGITS: take = 1'b1;
         default: begin
            if (lst) begin
               phase_in = PH_WS;
            end
         end
      endcase

      if (first) begin
         if (c == "0" && (cur_base == 6'd0 || cur_base == 6'd16)) begin
            base_in     = (cur_base == 6'd0) ? 6'd8 : 6'd16;
            acc_in      = '0;
            digits_in   = 1'b1;
            pos_in      = pos_adv;
            fallback_in = pos_adv;
            phase_in    = PH_ZERO;
            conclude    = lst;
            conc_end    = pos_adv;
         end else begin
            take_base = (cur_base == 6'd0) ? 6'd10 : cur_base;
            base_in   = take_base;
            take      = 1'b1;
         end
      end

      if (take) begin
         if (dig >= {2'b0, take_base}) begin
            conclude = 1'b1;
            conc_end = pos_ff;
         end else begin
            prod      = (VALUE_WIDTH+6)'(acc_ff) * (VALUE_WIDTH+6)'(take_base)
                        + (VALUE_WIDTH+6)'(dig);
            ovf_in    = ovf_ff || (prod[VALUE_WIDTH+5:VALUE_WIDTH] != 6'd0);
            acc_in    = prod[VALUE_WIDTH-1:0];
            digits_in = 1'b1;
            pos_in    = pos_adv;
            phase_in  = PH_DIGITS;
            conclude  = lst;
            conc_end  = pos_adv;
         end
      end

      // Form the result from the updated state.
      v = ovf_in ? ALL_ONES : acc_in;
      rsp_payload_in.end_index = conc_end;
      if (bad_base) begin
         rsp_payload_in.value     = '0;
         rsp_payload_in.end_index = '0;
         rsp_payload_in.status    = ST_BAD_BASE;
      end else if (!digits_in) begin
         rsp_payload_in.value     = '0;
         rsp_payload_in.end_index = '0;
         rsp_payload_in.status    = ST_NO_CONV;
      end else if (signed_mode_ff) begin
         if (v >= HALF_VAL) begin
            if (v == HALF_VAL && neg_in) begin
               rsp_payload_in.value  = HALF_VAL;
               rsp_payload_in.status = ST_OK;
            end else begin
               rsp_payload_in.value  = neg_in ? HALF_VAL : HALF_VAL - 1'b1;
               rsp_payload_in.status = ST_OVERFLOW;
            end
         end else begin
            rsp_payload_in.value  = neg_in ? (~v + 1'b1) : v;
            rsp_payload_in.status = ST_OK;
         end
      end else if (ovf_in) begin
         rsp_payload_in.value  = ALL_ONES;
         rsp_payload_in.status = ST_OVERFLOW;
      end else begin
         rsp_payload_in.value  = neg_in ? (~v + 1'b1) : v;
         rsp_payload_in.status = ST_OK;
      end

      res_fire = bad_base || conclude;

      // A result ends the number: start over on last, else drain the string.
      if (res_fire) begin
         if (lst) begin
            phase_in    = PH_WS;
            acc_in      = '0;
            ovf_in      = 1'b0;
            neg_in      = 1'b0;
            base_in     = '0;
            pos_in      = '0;
            fallback_in = '0;
            digits_in   = 1'b0;
         end else begin
            phase_in = PH_DRAIN;
         end
      end else if (phase_ff > PH_DIGITS && lst) begin
         acc_in      = '0;
         ovf_in      = 1'b0;
         neg_in      = 1'b0;
         base_in     = '0;
         pos_in      = '0;
         fallback_in = '0;
         digits_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_payload_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_WS;
         acc_ff      <= '0;
         ovf_ff      <= 1'b0;
         neg_ff      <= 1'b0;
         base_ff     <= '0;
         pos_ff      <= '0;
         fallback_ff <= '0;
         digits_ff   <= 1'b0;
      end else if (proc_go) begin
         phase_ff    <= phase_in;
         acc_ff      <= acc_in;
         ovf_ff      <= ovf_in;
         neg_ff      <= neg_in;
         base_ff     <= base_in;
         pos_ff      <= pos_in;
         fallback_ff <= fallback_in;
         digits_ff   <= digits_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc_go && res_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_go && res_fire) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A character that makes a result must show up on the result register.
   a_fire_lands: assert property (@(posedge clock) disable iff (reset)
      proc_go && res_fire |=> rsp_valid_ff)
      else $error("result step did not load the result register");

   // Failed conversions always report a zero value at index zero.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_payload_ff.status == ST_BAD_BASE ||
                       rsp_payload_ff.status == ST_NO_CONV)
      |-> (rsp_payload_ff.value == '0 && rsp_payload_ff.end_index == '0))
      else $error("failed conversion with nonzero value or index");

   // The digit phase is only reachable after a digit was taken.
   a_digits_seen: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DIGITS |-> digits_ff)
      else $error("digit phase without any digit");

   // Overflow in signed mode clamps to one of the two signed limits.
   a_signed_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && signed_mode_ff && rsp_payload_ff.status == ST_OVERFLOW
      |-> (rsp_payload_ff.value == HALF_VAL || rsp_payload_ff.value == HALF_VAL - 1'b1))
      else $error("signed overflow value is not a limit");

   // The input stage stalls only while it holds a character that cannot move.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && res_fire && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked result");

endmodule

>>> sim/text_to_integer_parser_checker.sv
`timescale 1ns / 1ps

module text_to_integer_parser_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  ttoi_pkg::req_payload_type req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  ttoi_pkg::rsp_payload_type rsp_payload,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic                      pready,
   input  logic [2:0]                paddr,
   input  logic [31:0]               pwdata,
   output int unsigned               pending,
   output int unsigned               mismatches
);
   import ttoi_pkg::*;

   localparam int unsigned        PRINT_LIMIT     = 200;
   localparam logic [5:0]         HIGHEST_RADIX   = 6'd36;
   localparam logic [5:0]         RESET_RADIX     = 6'd10;
   localparam logic [31:0]        SIGNED_MIN_BITS = 32'h8000_0000;
   localparam logic [31:0]        SIGNED_MAX_BITS = 32'h7FFF_FFFF;

   typedef enum logic [2:0] {
      SKIP_SPACE,
      AFTER_SIGN,
      AFTER_ZERO,
      AFTER_ZERO_X,
      IN_DIGITS,
      DRAIN
   } scan_phase_type;

   logic [5:0]      radix_reg;
   logic            signed_reg;

   scan_phase_type  phase;
   logic [31:0]     accum;
   logic            ovf_sticky;
   logic            minus;
   logic [5:0]      base;
   logic [15:0]     pos;
   logic [15:0]     prefix_end;
   logic            any_digit;

   rsp_payload_type conversions_due[$];
   rsp_payload_type want;

   function automatic logic [7:0] char_weight(input logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "Z") return c - "A" + 8'd10;
      if (c >= "a" && c <= "z") return c - "a" + 8'd10;
      return NOT_A_DIGIT;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == " ") || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   task automatic new_string();
      phase      = SKIP_SPACE;
      accum      = '0;
      ovf_sticky = 1'b0;
      minus      = 1'b0;
      base       = '0;
      pos        = '0;
      prefix_end = '0;
      any_digit  = 1'b0;
   endtask

   task automatic bump_position();
      if (pos != MAX_LEN) pos = pos + 16'd1;
   endtask

   task automatic post_result(input logic [31:0] v, input logic [15:0] e,
                              input logic [1:0] st, input logic lst);
      rsp_payload_type r;
      r.value     = v;
      r.end_index = e;
      r.status    = st;
      conversions_due.push_back(r);
      if (lst) new_string();
      else phase = DRAIN;
   endtask

   // The sticky overflow forces the magnitude to all ones before clamping.
   task automatic finish_number(input logic [15:0] e, input logic lst);
      logic [31:0] v;
      v = ovf_sticky ? '1 : accum;
      if (!any_digit) begin
         post_result('0, '0, ST_NO_CONV, lst);
      end else if (signed_reg) begin
         if (v[31]) begin
            if (v == SIGNED_MIN_BITS && minus) post_result(v, e, ST_OK, lst);
            else post_result(minus ? SIGNED_MIN_BITS : SIGNED_MAX_BITS, e, ST_OVERFLOW, lst);
         end else begin
            post_result(minus ? 32'd0 - v : v, e, ST_OK, lst);
         end
      end else if (ovf_sticky) begin
         post_result('1, e, ST_OVERFLOW, lst);
      end else begin
         post_result(minus ? 32'd0 - v : v, e, ST_OK, lst);
      end
   endtask

   task automatic take_digit(input logic [7:0] c, input logic lst);
      logic [7:0]  d;
      logic [63:0] product;
      d = char_weight(c);
      if (d >= {2'b00, base}) begin
         finish_number(pos, lst);
      end else begin
         product = {32'd0, accum} * {58'd0, base} + {56'd0, d};
         if (product[63:32] != 32'd0) ovf_sticky = 1'b1;
         accum     = product[31:0];
         any_digit = 1'b1;
         bump_position();
         phase = IN_DIGITS;
         if (lst) finish_number(pos, lst);
      end
   endtask

   // A leading zero picks octal under auto-detect and may start a hex prefix.
   task automatic first_digit(input logic [7:0] c, input logic lst);
      if (c == "0" && (base == 6'd0 || base == 6'd16)) begin
         base      = (base == 6'd0) ? 6'd8 : 6'd16;
         accum     = '0;
         any_digit = 1'b1;
         bump_position();
         prefix_end = pos;
         phase      = AFTER_ZERO;
         if (lst) finish_number(pos, lst);
      end else begin
         if (base == 6'd0) base = 6'd10;
         take_digit(c, lst);
      end
   endtask

   task automatic parse_char(input logic [7:0] c, input logic lst);
      case (phase)
         SKIP_SPACE: begin
            base = radix_reg;
            if (radix_reg == 6'd1 || radix_reg > HIGHEST_RADIX) begin
               post_result('0, '0, ST_BAD_BASE, lst);
            end else if (is_blank(c)) begin
               bump_position();
               if (lst) finish_number(pos, lst);
            end else if (c == "-" || c == "+") begin
               minus = (c == "-");
               bump_position();
               phase = AFTER_SIGN;
               if (lst) finish_number(pos, lst);
            end else begin
               first_digit(c, lst);
            end
         end
         AFTER_SIGN: first_digit(c, lst);
         AFTER_ZERO: begin
            if (c == "x" || c == "X") begin
               phase = AFTER_ZERO_X;
               bump_position();
               if (lst) finish_number(prefix_end, lst);
            end else begin
               take_digit(c, lst);
            end
         end
         AFTER_ZERO_X: begin
            if (char_weight(c) < 8'd16) begin
               base = 6'd16;
               take_digit(c, lst);
            end else begin
               finish_number(prefix_end, lst);
            end
         end
         IN_DIGITS: take_digit(c, lst);
         default: if (lst) new_string();
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_bits);
      if (mismatches < PRINT_LIMIT)
         $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_bits);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         radix_reg  = RESET_RADIX;
         signed_reg = 1'b0;
         new_string();
         conversions_due.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == {REG_RADIX, 2'b00}) radix_reg = pwdata[5:0];
            else if (paddr == {REG_SIGNED, 2'b00}) signed_reg = pwdata[0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (conversions_due.size() == 0) begin
               report_mismatch("result transfer with none expected", rsp_payload.value, '0);
            end else begin
               want = conversions_due.pop_front();
               if (rsp_payload.value !== want.value)
                  report_mismatch("value", rsp_payload.value, want.value);
               if (rsp_payload.end_index !== want.end_index)
                  report_mismatch("end_index", 32'(rsp_payload.end_index),
                                  32'(want.end_index));
               if (rsp_payload.status !== want.status)
                  report_mismatch("status", 32'(rsp_payload.status), 32'(want.status));
            end
         end
         if (req_valid && !req_stall) parse_char(req_payload.ch, req_payload.last);
      end
      pending = conversions_due.size();
   end

endmodule

>>> sim/tb_text_to_integer_parser.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the text-to-integer parser. A separate checker
// watches all three ports, predicts every conversion result and counts
// mismatches; this module only drives characters, configuration and the
// receiver stall, and then decides pass or fail.
module tb_text_to_integer_parser;
   import ttoi_pkg::*;

   localparam int unsigned IDLE_PERCENT    = 7;
   localparam int unsigned HOLD_OFF_CYCLES = 150;
   localparam int unsigned WATCHDOG_LIMIT  = 2000;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned RANDOM_ITEMS    = 1350;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;
   logic            psel        = 1'b0;
   logic            penable     = 1'b0;
   logic            pwrite      = 1'b0;
   logic [2:0]      paddr       = '0;
   logic [31:0]     pwdata      = '0;
   logic [31:0]     prdata;
   logic            pready;

   int unsigned     pending;
   int unsigned     mismatches;

   // When calm is set neither side idles. A request for a hold-off is
   // picked up by the receiver process, which then counts the cycles itself.
   bit              calm        = 1'b0;
   bit              hold_off_go = 1'b0;
   int unsigned     chars_sent  = 0;
   int unsigned     cur_radix   = 10;
   int unsigned     quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   text_to_integer_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   text_to_integer_parser_checker parse_monitor (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pending    (pending),
      .mismatches (mismatches)
   );

   // The watchdog ends a run in which no transfer of any kind has happened for
   // far longer than the longest receiver hold-off.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Receiver: the stall changes only at the falling edge. It idles now and
   // then, except while calm, and holds off completely when asked to, so that
   // the block backs up and stalls its input.
   initial begin : receiver
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            hold_left   = HOLD_OFF_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   // All driving tasks start and end just after a falling edge.
   task automatic write_reg(input logic index, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_config(input int unsigned radix, input bit signed_on);
      write_reg(REG_RADIX, radix);
      write_reg(REG_SIGNED, 32'(signed_on));
      cur_radix = radix;
   endtask

   // One character transfer. Valid stays high from one character to the next
   // unless an idle cycle is drawn, and the payload holds while stalled.
   task automatic send_char(input logic [7:0] c, input logic lst);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{ch: c, last: lst};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input bit lst);
      for (int i = 0; i < s.len(); i++) send_char(s[i], lst && (i == s.len() - 1));
   endtask

   // Configuration may only change with nothing in flight. A character that
   // makes no result can still be inside the block when the last expected
   // result has arrived, hence the extra settle cycles.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Most strings are well formed for the current radix: optional blanks, an
   // optional sign, an optional zero or hex prefix, digits, and then either
   // last on the final digit or a terminator followed by trailing junk. The
   // rest are short runs of arbitrary bytes.
   task automatic send_random_string();
      logic [7:0]  text[$];
      logic [7:0]  c;
      int unsigned digit_base;
      int unsigned n_digits;
      int unsigned d;
      bit          all_max;
      text = {};
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(6, 1)) begin
            c = 8'($urandom_range(255));
            text.push_back(c);
         end
      end else begin
         repeat ($urandom_range(3, 0)) begin
            c = $urandom_range(1) ? 8'h20 : 8'($urandom_range(13, 9));
            text.push_back(c);
         end
         case ($urandom_range(3))
            0: text.push_back("-");
            1: text.push_back("+");
            default: ;
         endcase
         digit_base = cur_radix;
         if (cur_radix == 0 || cur_radix == 16) begin
            case ($urandom_range(3))
               0: begin
                  text.push_back("0");
                  digit_base = (cur_radix == 0) ? 8 : 16;
               end
               1: begin
                  text.push_back("0");
                  text.push_back($urandom_range(1) ? "x" : "X");
                  digit_base = 16;
               end
               default: if (cur_radix == 0) digit_base = 10;
            endcase
         end
         // With an invalid radix the content does not matter.
         if (digit_base < 2 || digit_base > 36) digit_base = 10;
         n_digits = ($urandom_range(7) == 0) ? $urandom_range(14, 9) : $urandom_range(8, 0);
         all_max  = ($urandom_range(7) == 0);
         repeat (n_digits) begin
            d = all_max ? digit_base - 1 : $urandom_range(digit_base - 1);
            if (d < 10) c = 8'("0" + d);
            else c = 8'(($urandom_range(1) ? "a" : "A") + d - 10);
            text.push_back(c);
         end
         if ($urandom_range(1) || text.size() == 0) begin
            case ($urandom_range(4))
               0: text.push_back(" ");
               1: text.push_back(";");
               2: text.push_back(".");
               3: text.push_back(8'h00);
               default: begin
                  c = 8'($urandom_range(255));
                  text.push_back(c);
               end
            endcase
            repeat ($urandom_range(3)) begin
               c = 8'($urandom_range(255));
               text.push_back(c);
            end
         end
      end
      for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
   endtask

   initial begin : stimulus
      int unsigned stop_at;
      int unsigned round;
      int unsigned radix;
      bit          bad_radix;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Auto-detect: blanks and a minus sign before a hex number that ends on
      // last, a zero-x prefix without a hex digit after it, an octal number
      // ended by a NUL byte, and a string of only a blank and a sign.
      set_config(0, 0);
      send_text(" -0x1F", 1'b1);
      send_text("0xg;", 1'b1);
      send_text("017", 1'b0);
      send_char(8'h00, 1'b1);
      send_text("\t+", 1'b1);

      // Invalid bases fail on the first character and the rest is drained.
      wait_idle();
      set_config(1, 0);
      send_char("5", 1'b0);
      send_char(8'hFF, 1'b1);
      wait_idle();
      set_config(63, 1);
      send_text(" 7", 1'b1);

      // Base 36 in signed mode: exactly the most negative value, then a
      // positive overflow that clamps.
      wait_idle();
      set_config(36, 1);
      send_text("-zik0zk", 1'b1);
      send_text("ZZZZZZZ", 1'b1);

      // Random rounds, each under a fresh configuration. One round runs with
      // no idling at all, and one starts with a long receiver hold-off.
      stop_at = chars_sent + RANDOM_ITEMS;
      round   = 0;
      while (chars_sent < stop_at) begin
         wait_idle();
         case ($urandom_range(7))
            0: radix = 0;
            1: radix = 10;
            2: radix = 16;
            3: radix = 8;
            4: radix = 2;
            5: radix = 36;
            6: radix = $urandom_range(1) ? 1 : $urandom_range(63, 37);
            default: radix = $urandom_range(36, 2);
         endcase
         bad_radix = (radix == 1 || radix > 36);
         set_config(radix, 1'($urandom_range(1)));
         calm = (round == 2);
         if (round == 4) hold_off_go = 1'b1;
         repeat (bad_radix ? 5 : 25) send_random_string();
         round++;
      end
      calm = 1'b0;

      wait_idle();
      if (mismatches == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/ttoi_pkg.sv
rtl/text_to_integer_parser.sv
sim/text_to_integer_parser_checker.sv
sim/tb_text_to_integer_parser.sv
